@@ rtl/rrsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rrsa_pkg
// Shared types and codes of the round-robin slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rrsa_pkg;

  localparam int unsigned MaxSlotsDefault = 10;
  localparam int unsigned CountW          = 4;
  localparam int unsigned SlotW           = 8;

  typedef enum logic [1:0] {
    CMD_CLAIM_ANY   = 2'd0,
    CMD_CLAIM_GIVEN = 2'd1,
    CMD_RELEASE     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [SlotW-1:0] slot;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CountW-1:0] granted_slot;
  } out_word_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic              clr_all;
    logic [CountW-1:0] slot;
  } lock_op_t;

endpackage

`default_nettype wire

@@ rtl/rrsa_step.sv @@
// ----------------------------------------------------------------------------
// rrsa_step
// Shared cursor step unit: increment with wrap at the slot count.
// ----------------------------------------------------------------------------
`default_nettype none

module rrsa_step (
  input  wire logic [rrsa_pkg::CountW-1:0] cur_i,
  input  wire logic [rrsa_pkg::CountW-1:0] count_i,
  output logic      [rrsa_pkg::CountW-1:0] next_o
);

  logic [rrsa_pkg::CountW:0] inc;

  assign inc    = {1'b0, cur_i} + {{rrsa_pkg::CountW{1'b0}}, 1'b1};
  assign next_o = (inc >= {1'b0, count_i}) ? '0 : inc[rrsa_pkg::CountW-1:0];

endmodule

`default_nettype wire

@@ rtl/rrsa_lock_file.sv @@
// ----------------------------------------------------------------------------
// rrsa_lock_file
// One lock flag per slot, with set, clear, clear-all and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rrsa_lock_file #(
  parameter int unsigned MAX_SLOTS = rrsa_pkg::MaxSlotsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rrsa_pkg::lock_op_t              op_i,
  input  wire logic [rrsa_pkg::CountW-1:0]     rd_slot_i,
  output logic                                 locked_o
);

  localparam int unsigned IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [MAX_SLOTS-1:0] flags_q;
  logic [MAX_SLOTS-1:0] flags_d;
  logic [IdxW-1:0]      wr_idx;
  logic [IdxW-1:0]      rd_idx;
  logic                 wr_ok;
  logic                 rd_ok;

  assign wr_idx = IdxW'(op_i.slot);
  assign rd_idx = IdxW'(rd_slot_i);
  assign wr_ok  = 32'(op_i.slot) < 32'(MAX_SLOTS);
  assign rd_ok  = 32'(rd_slot_i) < 32'(MAX_SLOTS);

  assign locked_o = rd_ok ? flags_q[rd_idx] : 1'b1;

  always_comb begin
    flags_d = flags_q;
    if (op_i.clr_all) begin
      flags_d = '0;
    end else if (op_i.set && wr_ok) begin
      flags_d[wr_idx] = 1'b1;
    end else if (op_i.clr && wr_ok) begin
      flags_d[wr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rrsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrsa_ctrl
// Command sequencer: holds the slot count and cursor, walks the search one
// slot per cycle through the shared step unit, and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rrsa_ctrl #(
  parameter int unsigned MAX_SLOTS = rrsa_pkg::MaxSlotsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire rrsa_pkg::in_word_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output rrsa_pkg::out_word_t              out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [rrsa_pkg::CountW-1:0] cfg_data_i,
  input  wire logic                        locked_i,
  output logic [rrsa_pkg::CountW-1:0]      rd_slot_o,
  output rrsa_pkg::lock_op_t               lock_op_o
);

  localparam int unsigned CW = rrsa_pkg::CountW;
  localparam int unsigned SW = rrsa_pkg::SlotW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_RESULT
  } state_e;

  state_e              state_q;
  rrsa_pkg::in_word_t  word_q;
  rrsa_pkg::out_word_t out_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       cursor_q;
  logic [CW-1:0]       cur_q;
  logic [CW-1:0]       tried_q;
  logic [CW-1:0]       tried_inc;
  logic [CW-1:0]       next_cur;
  logic [CW-1:0]       start_cur;
  logic                cfg_apply;
  logic                in_range;

  rrsa_step u_step (
    .cur_i   (cur_q),
    .count_i (count_q),
    .next_o  (next_cur)
  );

  assign cfg_ready_o = 1'b1;
  assign cfg_apply   = cfg_valid_i && (32'(cfg_data_i) <= 32'(MAX_SLOTS));
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESULT);
  assign out_data_o  = out_q;
  assign in_range    = {{(SW-CW){1'b0}}, count_q} > word_q.slot;
  assign start_cur   = (cursor_q >= count_q) ? '0 : cursor_q;
  assign tried_inc   = tried_q + {{(CW-1){1'b0}}, 1'b1};
  assign rd_slot_o   = (state_q == S_SEARCH) ? cur_q : word_q.slot[CW-1:0];

  always_comb begin
    lock_op_o         = '0;
    lock_op_o.clr_all = cfg_apply;
    lock_op_o.slot    = word_q.slot[CW-1:0];
    case (state_q)
      S_EXEC: begin
        if (word_q.command == rrsa_pkg::CMD_CLAIM_GIVEN && in_range && !locked_i) begin
          lock_op_o.set = 1'b1;
        end else if (word_q.command == rrsa_pkg::CMD_RELEASE && in_range) begin
          lock_op_o.clr = 1'b1;
        end
      end
      S_SEARCH: begin
        lock_op_o.slot = cur_q;
        lock_op_o.set  = !locked_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      cur_q    <= '0;
      tried_q  <= '0;
      word_q   <= '0;
      out_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            word_q  <= in_data_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_q.granted_slot <= '0;
          out_q.status       <= rrsa_pkg::ST_FAIL;
          state_q            <= S_RESULT;
          case (word_q.command)
            rrsa_pkg::CMD_CLAIM_ANY: begin
              if (count_q != '0) begin
                cur_q   <= start_cur;
                tried_q <= '0;
                state_q <= S_SEARCH;
              end
            end
            rrsa_pkg::CMD_CLAIM_GIVEN: begin
              if (in_range && !locked_i) begin
                out_q.status       <= rrsa_pkg::ST_OK;
                out_q.granted_slot <= word_q.slot[CW-1:0];
              end
            end
            rrsa_pkg::CMD_RELEASE: begin
              out_q.status <= in_range ? rrsa_pkg::ST_OK : rrsa_pkg::ST_RANGE;
            end
            default: begin
            end
          endcase
        end
        S_SEARCH: begin
          cursor_q <= next_cur;
          if (!locked_i) begin
            out_q.status       <= rrsa_pkg::ST_OK;
            out_q.granted_slot <= cur_q;
            state_q            <= S_RESULT;
          end else if (tried_inc == count_q) begin
            state_q <= S_RESULT;
          end else begin
            tried_q <= tried_inc;
            cur_q   <= next_cur;
          end
        end
        S_RESULT: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (cfg_apply) begin
        count_q  <= cfg_data_i;
        cursor_q <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/round_robin_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// round_robin_slot_allocator
// Round-robin allocator over a configured number of lockable slots.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one command word:
// claim any free slot, claim a given slot, or release a given slot. Output
// channel (out_valid_o/out_ready_i/out_data_o) returns one result word per
// command: status and granted slot.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the slot count;
// a value above MAX_SLOTS is dropped, an accepted one frees every slot and
// zeroes the search cursor. Write it only while no command is in flight.
// Claim-given, release and unused codes go from the execute state straight to
// the result; claim-any with a nonzero slot count goes on to a search state
// that tries slots in turn, one per cycle through the shared cursor step unit.
// One command is in flight at a time; in_ready_o rises the cycle after the
// result word is taken.
// A stalled receiver holds the result word and the block takes no command.
// Reset frees every slot and zeroes the slot count and the cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_slot_allocator #(
  parameter int unsigned MAX_SLOTS = rrsa_pkg::MaxSlotsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire rrsa_pkg::in_word_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output rrsa_pkg::out_word_t              out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [rrsa_pkg::CountW-1:0] cfg_data_i
);

  rrsa_pkg::lock_op_t              lock_op;
  logic [rrsa_pkg::CountW-1:0]     rd_slot;
  logic                            locked;

  rrsa_lock_file #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_lock_file (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (lock_op),
    .rd_slot_i (rd_slot),
    .locked_o  (locked)
  );

  rrsa_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .locked_i    (locked),
    .rd_slot_o   (rd_slot),
    .lock_op_o   (lock_op)
  );

endmodule

`default_nettype wire
